// ===== design/ssb_pkg.sv =====
// Shared widths, register index codes and the in-flight item record for the slope blend.
`timescale 1ns / 1ps
package ssb_pkg;

  // Field widths of the channels.
  localparam int COORD_W    = 10;
  localparam int H_W        = 24;
  localparam int R_W        = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Internal widths that follow from the coordinate range.
  localparam int LEN2_W = 21;  // squared planar length, at most 2 * 1023^2
  localparam int C2_W   = 42;  // squared cross product
  localparam int T_W    = 17;  // Q0.16 position, 1.0 included
  localparam int TNUM_W = 38;  // dividend of the position division
  localparam int DQ_W   = 37;  // squared distance in Q.16
  localparam int DNUM_W = 58;  // dividend of the distance division
  localparam int RAD_W  = 38;  // radicand, padded to an even width
  localparam int DIST_W = 19;  // distance in Q11.8
  localparam int F_W    = 17;  // Q0.16 blend factor, 1.0 included
  localparam int FNUM_W = 32;  // dividend of the factor division
  localparam int TGT_W  = 26;  // ramp height with headroom

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd6;

  localparam logic [R_W-1:0] RADIUS_RESET = 16'd768;

  // Where the projection falls on the segment.
  localparam logic [1:0] CLS_LO  = 2'd0;
  localparam logic [1:0] CLS_MID = 2'd1;
  localparam logic [1:0] CLS_HI  = 2'd2;

  // Everything an item carries down the pipe besides the values in flight in a unit.
  typedef struct packed {
    logic signed [H_W-1:0]   cur;
    logic                    active;
    logic [1:0]              cls;
    logic [LEN2_W-1:0]       len2;
    logic [LEN2_W-1:0]       pq2;
    logic [C2_W-1:0]         c2;
    logic signed [TGT_W-1:0] target;
  } ssb_item_t;

endpackage

// ===== design/ssb_vertex_if.sv =====
// Channel interfaces: vertex items, result items and configuration writes.
`timescale 1ns / 1ps
interface ssb_vertex_if import ssb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] vertex_x;
  logic [COORD_W-1:0] vertex_z;
  logic [H_W-1:0]     current_height;

  modport source (output valid, vertex_x, vertex_z, current_height, input ready);
  modport sink (input valid, vertex_x, vertex_z, current_height, output ready);
endinterface

interface ssb_result_if import ssb_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [H_W-1:0] new_height;
  logic           was_changed;

  modport source (output valid, new_height, was_changed, input ready);
  modport sink (input valid, new_height, was_changed, output ready);
endinterface

interface ssb_cfg_if import ssb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/smoothstep_slope_blend.sv =====
// Top level of the smooth slope blend: configuration registers and the full item pipeline.
`timescale 1ns / 1ps
// Usage overview.
// The block reshapes one terrain vertex per item. A vertex item (grid x, grid z and the
// present Q16.8 height) enters on the vertex channel and one result item (new height and
// a changed flag) leaves on the result channel for every vertex, in order.
// The cfg channel writes the slope's start and end points, their heights and the
// influence radius; its ready is always high, and writes are expected only while no item
// is in flight. Writes to an index beyond the radius register are ignored.
// Throughput is one item per clock while no result waits unclaimed. The pipe has 103
// register stages. The length is set by the three bit-serial divider pipelines
// (position, squared distance, blend factor) and the 19-stage square root, one result
// bit per stage each.
// The result register parts the pipe from the receiver. When a result waits and the
// receiver is not ready, every stage holds and vertex ready drops, so nothing is lost or
// repeated; bubbles in the pipe do not block acceptance while the result register is
// empty or being drained.
// A synchronous reset empties the pipe and sets the radius to 3.0 and all other
// configuration registers to zero.
module smoothstep_slope_blend import ssb_pkg::*; #(
  parameter int GRID_SIZE = 1024
) (
  input logic         clk,
  input logic         rst,
  ssb_cfg_if.sink     cfg,
  ssb_vertex_if.sink  vertex,
  ssb_result_if.source result
);

  localparam logic [12:0] GRID_LIM = 13'(GRID_SIZE);

  // Configuration registers.
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_z;
  logic [H_W-1:0]     start_height;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_z;
  logic [H_W-1:0]     end_height;
  logic [R_W-1:0]     radius;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x      <= '0;
      start_z      <= '0;
      start_height <= '0;
      end_x        <= '0;
      end_z        <= '0;
      end_height   <= '0;
      radius       <= RADIUS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_START_X:      start_x      <= cfg.data[COORD_W-1:0];
        REG_START_Z:      start_z      <= cfg.data[COORD_W-1:0];
        REG_START_HEIGHT: start_height <= cfg.data[H_W-1:0];
        REG_END_X:        end_x        <= cfg.data[COORD_W-1:0];
        REG_END_Z:        end_z        <= cfg.data[COORD_W-1:0];
        REG_END_HEIGHT:   end_height   <= cfg.data[H_W-1:0];
        REG_RADIUS:       radius       <= cfg.data[R_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipe advances together; it stops only while a result waits unclaimed.
  logic res_valid;
  logic en;

  assign en           = !res_valid || result.ready;
  assign vertex.ready = en;

  // Stage 1: offsets from both end points and the segment direction.
  logic               s1_v;
  logic signed [10:0] s1_px, s1_pz, s1_qx, s1_qz, s1_dx, s1_dz;
  logic signed [H_W-1:0] s1_cur;
  logic               s1_act;
  logic               act_n;

  assign act_n = ({3'b000, vertex.vertex_x} < GRID_LIM) &&
                 ({3'b000, vertex.vertex_z} < GRID_LIM) &&
                 ((start_x != end_x) || (start_z != end_z)) && (radius != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= vertex.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px  <= $signed({1'b0, vertex.vertex_x}) - $signed({1'b0, start_x});
      s1_pz  <= $signed({1'b0, vertex.vertex_z}) - $signed({1'b0, start_z});
      s1_qx  <= $signed({1'b0, vertex.vertex_x}) - $signed({1'b0, end_x});
      s1_qz  <= $signed({1'b0, vertex.vertex_z}) - $signed({1'b0, end_z});
      s1_dx  <= $signed({1'b0, end_x}) - $signed({1'b0, start_x});
      s1_dz  <= $signed({1'b0, end_z}) - $signed({1'b0, start_z});
      s1_cur <= $signed(vertex.current_height);
      s1_act <= act_n;
    end
  end

  // Stage 2: dot and cross products and squared lengths, all from 11-bit factors.
  logic signed [21:0] m_pxdx, m_pzdz, m_pxdz, m_pzdx, m_dxdx, m_dzdz;
  logic signed [21:0] m_pxpx, m_pzpz, m_qxqx, m_qzqz;

  assign m_pxdx = s1_px * s1_dx;
  assign m_pzdz = s1_pz * s1_dz;
  assign m_pxdz = s1_px * s1_dz;
  assign m_pzdx = s1_pz * s1_dx;
  assign m_dxdx = s1_dx * s1_dx;
  assign m_dzdz = s1_dz * s1_dz;
  assign m_pxpx = s1_px * s1_px;
  assign m_pzpz = s1_pz * s1_pz;
  assign m_qxqx = s1_qx * s1_qx;
  assign m_qzqz = s1_qz * s1_qz;

  logic               s2_v;
  logic signed [22:0] s2_dot, s2_cross;
  logic [LEN2_W-1:0]  s2_len2, s2_p2, s2_q2;
  logic signed [H_W-1:0] s2_cur;
  logic               s2_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dot   <= $signed({m_pxdx[21], m_pxdx}) + $signed({m_pzdz[21], m_pzdz});
      s2_cross <= $signed({m_pxdz[21], m_pxdz}) - $signed({m_pzdx[21], m_pzdx});
      s2_len2  <= m_dxdx[LEN2_W-1:0] + m_dzdz[LEN2_W-1:0];
      s2_p2    <= m_pxpx[LEN2_W-1:0] + m_pzpz[LEN2_W-1:0];
      s2_q2    <= m_qxqx[LEN2_W-1:0] + m_qzqz[LEN2_W-1:0];
      s2_cur   <= s1_cur;
      s2_act   <= s1_act;
    end
  end

  // Stage 3: where the projection falls, the clamped squared distance, the squared
  // cross product and the rounded position dividend.
  logic               lo_n, hi_n;
  logic [1:0]         cls_n;
  logic signed [22:0] cabs_s;
  logic [LEN2_W-1:0]  cabs;

  assign lo_n   = s2_dot[22] || (s2_dot == '0);
  assign hi_n   = !lo_n && (s2_dot >= $signed({2'b00, s2_len2}));
  assign cls_n  = lo_n ? CLS_LO : (hi_n ? CLS_HI : CLS_MID);
  assign cabs_s = s2_cross[22] ? -s2_cross : s2_cross;
  assign cabs   = cabs_s[LEN2_W-1:0];

  logic              s3_v;
  ssb_item_t         s3_item;
  logic [TNUM_W-1:0] s3_tnum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_item.cur    <= s2_cur;
      s3_item.active <= s2_act;
      s3_item.cls    <= cls_n;
      s3_item.len2   <= s2_len2;
      s3_item.pq2    <= lo_n ? s2_p2 : s2_q2;
      s3_item.c2     <= {21'b0, cabs} * {21'b0, cabs};
      s3_item.target <= '0;
      s3_tnum        <= (cls_n == CLS_MID) ?
                        ({1'b0, s2_dot[LEN2_W-1:0], 16'b0} + {18'b0, s2_len2[LEN2_W-1:1]}) :
                        '0;
    end
  end

  // Position t = round(dot * 65536 / len2) for the interior case.
  logic           tq_v;
  logic [T_W-1:0] tq_quo;
  ssb_item_t      tq_side;

  ssb_div #(
    .NUM_W  (TNUM_W),
    .DEN_W  (LEN2_W),
    .QUO_W  (T_W),
    .SIDE_W ($bits(ssb_item_t))
  ) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_v),
    .num      (s3_tnum),
    .den      (s3_item.len2),
    .side_in  (s3_item),
    .out_valid(tq_v),
    .quo      (tq_quo),
    .side_out (tq_side)
  );

  // Smoothstep and the ramp height, six stages.
  logic           t1_v, t2_v, t3_v, t4_v, t5_v, t6_v;
  ssb_item_t      t1_item, t2_item, t3_item, t4_item, t5_item, t6_item;
  ssb_item_t      t6_item_n;
  logic [T_W-1:0] t1_t;
  logic [33:0]    t2_tt;
  logic [17:0]    t2_w;
  logic [51:0]    t3_prod;
  logic [51:0]    t3_rnd;
  logic [T_W-1:0] t4_s16;
  logic signed [H_W:0]  t4_diffh;
  logic signed [42:0]   t5_m;
  logic signed [42:0]   t5_rnd;
  logic signed [42:0]   t5_sh;
  logic [DNUM_W-1:0]    t6_dnum;

  assign t3_rnd = t3_prod + 52'h0_0000_8000_0000;
  assign t5_rnd = t5_m + 43'sd32768;
  assign t5_sh  = t5_rnd >>> 16;

  // The item record of stage five with its ramp height filled in.
  always_comb begin
    t6_item_n        = t5_item;
    t6_item_n.target = $signed({{2{start_height[H_W-1]}}, start_height}) +
                       $signed(t5_sh[TGT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
      t3_v <= 1'b0;
      t4_v <= 1'b0;
      t5_v <= 1'b0;
      t6_v <= 1'b0;
    end else if (en) begin
      t1_v <= tq_v;
      t2_v <= t1_v;
      t3_v <= t2_v;
      t4_v <= t3_v;
      t5_v <= t4_v;
      t6_v <= t5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_item <= tq_side;
      t1_t    <= (tq_side.cls == CLS_LO) ? '0 :
                 ((tq_side.cls == CLS_HI) ? 17'h10000 : tq_quo);
      t2_item <= t1_item;
      t2_tt   <= {17'b0, t1_t} * {17'b0, t1_t};
      t2_w    <= 18'd196608 - {t1_t, 1'b0};
      t3_item <= t2_item;
      t3_prod <= {18'b0, t2_tt} * {34'b0, t2_w};
      t4_item <= t3_item;
      t4_s16  <= t3_rnd[48:32];
      t4_diffh <= $signed({end_height[H_W-1], end_height}) -
                  $signed({start_height[H_W-1], start_height});
      t5_item <= t4_item;
      t5_m    <= t4_diffh * $signed({1'b0, t4_s16});
      t6_item <= t6_item_n;
      t6_dnum <= (t5_item.active && (t5_item.cls == CLS_MID)) ? {t5_item.c2, 16'b0} : '0;
    end
  end

  // Squared distance cross^2 * 65536 / len2 for the interior case.
  logic            dq_v;
  logic [DQ_W-1:0] dq_quo;
  ssb_item_t       dq_side;

  ssb_div #(
    .NUM_W  (DNUM_W),
    .DEN_W  (LEN2_W),
    .QUO_W  (DQ_W),
    .SIDE_W ($bits(ssb_item_t))
  ) u_ddiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t6_v),
    .num      (t6_dnum),
    .den      (t6_item.len2),
    .side_in  (t6_item),
    .out_valid(dq_v),
    .quo      (dq_quo),
    .side_out (dq_side)
  );

  // Pick the interior or the end-point squared distance.
  logic             d1_v;
  ssb_item_t        d1_item;
  logic [RAD_W-1:0] d1_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
    end else if (en) begin
      d1_v <= dq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_item <= dq_side;
      d1_rad  <= (dq_side.cls == CLS_MID) ? {1'b0, dq_quo} : {1'b0, dq_side.pq2, 16'b0};
    end
  end

  logic              sq_v;
  logic [DIST_W-1:0] sq_root;
  ssb_item_t         sq_side;

  ssb_sqrt #(
    .RAD_W  (RAD_W),
    .SIDE_W ($bits(ssb_item_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d1_v),
    .rad      (d1_rad),
    .side_in  (d1_item),
    .out_valid(sq_v),
    .root     (sq_root),
    .side_out (sq_side)
  );

  // Radius test; from here on the active flag means the vertex is reshaped.
  logic              inr_n;
  logic              f0_v;
  ssb_item_t         f0_item;
  ssb_item_t         f0_item_n;
  logic [FNUM_W-1:0] f0_fnum;

  assign inr_n = sq_side.active && ({3'b000, radius} > sq_root);

  always_comb begin
    f0_item_n        = sq_side;
    f0_item_n.active = inr_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_v <= 1'b0;
    end else if (en) begin
      f0_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_item <= f0_item_n;
      f0_fnum <= inr_n ? {radius - sq_root[R_W-1:0], 16'b0} : '0;
    end
  end

  // Blend factor (radius - dist) * 65536 / radius.
  logic           fq_v;
  logic [F_W-1:0] fq_quo;
  ssb_item_t      fq_side;

  ssb_div #(
    .NUM_W  (FNUM_W),
    .DEN_W  (R_W),
    .QUO_W  (F_W),
    .SIDE_W ($bits(ssb_item_t))
  ) u_fdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f0_v),
    .num      (f0_fnum),
    .den      (radius),
    .side_in  (f0_item),
    .out_valid(fq_v),
    .quo      (fq_quo),
    .side_out (fq_side)
  );

  // Final lerp toward the ramp height, then round, saturate and register the result.
  logic               b1_v;
  ssb_item_t          b1_item;
  logic signed [44:0] b1_prod;
  logic signed [26:0] diff_n;

  assign diff_n = $signed({fq_side.target[TGT_W-1], fq_side.target}) -
                  $signed({{3{fq_side.cur[H_W-1]}}, fq_side.cur});

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (en) begin
      b1_v <= fq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_item <= fq_side;
      b1_prod <= diff_n * $signed({1'b0, fq_quo});
    end
  end

  logic signed [44:0] b_rnd;
  logic signed [44:0] b_sh;
  logic signed [29:0] nh;
  logic [H_W-1:0]     nh_sat;

  assign b_rnd = b1_prod + 45'sd32768;
  assign b_sh  = b_rnd >>> 16;
  assign nh    = $signed({{6{b1_item.cur[H_W-1]}}, b1_item.cur}) + $signed(b_sh[29:0]);

  always_comb begin
    if (nh < -30'sd8388608) begin
      nh_sat = 24'h800000;
    end else if (nh > 30'sd8388607) begin
      nh_sat = 24'h7FFFFF;
    end else begin
      nh_sat = nh[H_W-1:0];
    end
  end

  logic [H_W-1:0] res_height;
  logic           res_changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_height  <= b1_item.active ? nh_sat : b1_item.cur;
      res_changed <= b1_item.active;
    end
  end

  assign result.valid       = res_valid;
  assign result.new_height  = res_height;
  assign result.was_changed = res_changed;

  // A waiting result freezes the pipe, so the input side must be closed.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |-> !vertex.ready)
    else $error("input accepted while a result is stalled");

  // Reset empties the result register.
  a_reset_empties: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // An interior position never exceeds 1.0.
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    (tq_v && tq_side.active && (tq_side.cls == CLS_MID)) |-> (tq_quo <= 17'h10000))
    else $error("interior position out of range");

  // A vertex inside the radius gets a factor between one lsb and 1.0.
  a_f_range: assert property (@(posedge clk) disable iff (rst)
    (fq_v && fq_side.active) |-> ((fq_quo != '0) && (fq_quo <= 17'h10000)))
    else $error("blend factor out of range");

endmodule

// ===== design/ssb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
`timescale 1ns / 1ps
module ssb_div #(
  parameter int NUM_W  = 38,
  parameter int DEN_W  = 21,
  parameter int QUO_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  // The quotient must fit QUO_W bits, so the top of the dividend starts below den.
  logic              v   [QUO_W];
  logic [DEN_W-1:0]  rem [QUO_W];
  logic [QUO_W-1:0]  lq  [QUO_W];
  logic [DEN_W-1:0]  dv  [QUO_W];
  logic [SIDE_W-1:0] sd  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              sv;
    logic [DEN_W-1:0]  srem;
    logic [QUO_W-1:0]  slq;
    logic [DEN_W-1:0]  sdv;
    logic [SIDE_W-1:0] ssd;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    if (k == 0) begin : g_first
      assign sv   = in_valid;
      assign srem = DEN_W'(num >> QUO_W);
      assign slq  = num[QUO_W-1:0];
      assign sdv  = den;
      assign ssd  = side_in;
    end else begin : g_next
      assign sv   = v[k-1];
      assign srem = rem[k-1];
      assign slq  = lq[k-1];
      assign sdv  = dv[k-1];
      assign ssd  = sd[k-1];
    end

    assign trial = {srem, slq[QUO_W-1]};
    assign diff  = trial - {1'b0, sdv};
    assign fits  = (trial >= {1'b0, sdv});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lq[k]  <= {slq[QUO_W-2:0], fits};
        dv[k]  <= sdv;
        sd[k]  <= ssd;
      end
    end
  end

  assign out_valid = v[QUO_W-1];
  assign quo       = lq[QUO_W-1];
  assign side_out  = sd[QUO_W-1];

endmodule

// ===== design/ssb_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side payload.
`timescale 1ns / 1ps
module ssb_sqrt #(
  parameter int RAD_W  = 38,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [RAD_W-1:0]    rad,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [RAD_W/2-1:0]  root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int ROOT_W = RAD_W / 2;

  logic              v   [ROOT_W];
  logic [ROOT_W:0]   rem [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];
  logic [RAD_W-1:0]  rd  [ROOT_W];
  logic [SIDE_W-1:0] sd  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              sv;
    logic [ROOT_W:0]   srem;
    logic [ROOT_W-1:0] srt;
    logic [RAD_W-1:0]  srd;
    logic [SIDE_W-1:0] ssd;
    logic [ROOT_W+2:0] cur;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              fits;

    if (k == 0) begin : g_first
      assign sv   = in_valid;
      assign srem = '0;
      assign srt  = '0;
      assign srd  = rad;
      assign ssd  = side_in;
    end else begin : g_next
      assign sv   = v[k-1];
      assign srem = rem[k-1];
      assign srt  = rt[k-1];
      assign srd  = rd[k-1];
      assign ssd  = sd[k-1];
    end

    // Bring down the next two radicand bits and try the root with a one appended.
    assign cur   = {srem, srd[RAD_W-1 -: 2]};
    assign trial = {1'b0, srt, 2'b01};
    assign fits  = (cur >= trial);
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= fits ? diff[ROOT_W:0] : cur[ROOT_W:0];
        rt[k]  <= {srt[ROOT_W-2:0], fits};
        rd[k]  <= {srd[RAD_W-3:0], 2'b00};
        sd[k]  <= ssd;
      end
    end
  end

  assign out_valid = v[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign side_out  = sd[ROOT_W-1];

endmodule

// ===== tb/ssb_scoreboard.sv =====
// Scoreboard class: predicts the reshaped height of each vertex and checks result items.
`timescale 1ns / 1ps
import ssb_pkg::*;

class ssb_scoreboard;

  typedef struct {
    logic [H_W-1:0] height;
    logic           changed;
  } shaped_t;

  logic [COORD_W-1:0] sx, sz, ex, ez;
  longint             sh, eh;
  logic [R_W-1:0]     radius;
  shaped_t            pending[$];
  int                 errors;

  function new();
    sx = 0; sz = 0; ex = 0; ez = 0; sh = 0; eh = 0;
    radius = RADIUS_RESET;
    errors = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_START_X:      sx = d[COORD_W-1:0];
      REG_START_Z:      sz = d[COORD_W-1:0];
      REG_START_HEIGHT: sh = longint'($signed(d[H_W-1:0]));
      REG_END_X:        ex = d[COORD_W-1:0];
      REG_END_Z:        ez = d[COORD_W-1:0];
      REG_END_HEIGHT:   eh = longint'($signed(d[H_W-1:0]));
      REG_RADIUS:       radius = d[R_W-1:0];
      default: ;
    endcase
  endfunction

  // Integer square root by bit pairs.
  function longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Divide by 65536, rounding half toward plus infinity.
  function longint round16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function void note_vertex(logic [COORD_W-1:0] vx_in, logic [COORD_W-1:0] vz_in,
                            logic [H_W-1:0] h_in);
    longint vx, vz, cur, res, dx, dz, len2, px, pz, dot, t16, cr, f16, tgt, nh;
    longint unsigned d2q, seg_dist, s16, tu;
    shaped_t s;
    vx = vx_in; vz = vz_in;
    cur = longint'($signed(h_in));
    res = cur;
    s.changed = 0;
    dx = longint'(ex) - longint'(sx);
    dz = longint'(ez) - longint'(sz);
    if ((dx != 0 || dz != 0) && radius != 0) begin
      len2 = dx * dx + dz * dz;
      px = vx - sx; pz = vz - sz;
      dot = px * dx + pz * dz;
      if (dot <= 0) begin
        t16 = 0;
        d2q = (px * px + pz * pz) << 16;
      end else if (dot >= len2) begin
        t16 = 65536;
        d2q = ((vx - ex) * (vx - ex) + (vz - ez) * (vz - ez)) << 16;
      end else begin
        cr = px * dz - pz * dx;
        t16 = (dot * 65536 + len2 / 2) / len2;
        d2q = (longint'(cr * cr) * 65536) / len2;
      end
      seg_dist = root(d2q);
      if (seg_dist < radius) begin
        f16 = ((longint'(radius) - longint'(seg_dist)) << 16) / radius;
        tu = t16;
        s16 = (tu * tu * (196608 - 2 * tu) + (64'd1 << 31)) >> 32;
        tgt = sh + round16((eh - sh) * longint'(s16));
        nh = cur + round16((tgt - cur) * f16);
        if (nh < -8388608) nh = -8388608;
        if (nh > 8388607) nh = 8388607;
        res = nh;
        s.changed = 1;
      end
    end
    s.height = res[H_W-1:0];
    pending.push_back(s);
  endfunction

  function void check_result(logic [H_W-1:0] h, logic ch);
    shaped_t s;
    if (pending.size() == 0) begin
      $error("unexpected result item: new_height %0d", $signed(h));
      errors++;
      return;
    end
    s = pending.pop_front();
    if (h !== s.height) begin
      $error("new_height: expected %0d, got %0d", $signed(s.height), $signed(h));
      errors++;
    end
    if (ch !== s.changed) begin
      $error("was_changed: expected %0b, got %0b", s.changed, ch);
      errors++;
    end
  endfunction
endclass

// ===== tb/smoothstep_slope_blend_tb.sv =====
// Testbench top: drives vertices and configuration into the slope blend and checks results.
`timescale 1ns / 1ps
module smoothstep_slope_blend_tb import ssb_pkg::*; ();

  // The watchdog allows far more quiet cycles than the block's pipe depth plus the
  // longest receiver stall before declaring a hang.
  localparam int LATENCY = 103;
  localparam int HANG_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;

  ssb_cfg_if    cfg();
  ssb_vertex_if vertex();
  ssb_result_if result();

  smoothstep_slope_blend dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .vertex(vertex.sink), .result(result.source)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  ssb_scoreboard board = new();

  // Percent of cycles in which the sender idles and the receiver stalls.
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  initial begin
    cfg.valid = 0; cfg.index = REG_START_X; cfg.data = 0;
    vertex.valid = 0; vertex.vertex_x = 0; vertex.vertex_z = 0; vertex.current_height = 0;
  end

  // The receiver side: random stalls, and every accepted result is checked at the edge.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 0;
    end else begin
      if (result.valid && result.ready)
        board.check_result(result.new_height, result.was_changed);
      result.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Watchdog: a long run of cycles with no handshake on any channel means a hang.
  always @(posedge clk) begin
    if (rst || (vertex.valid && vertex.ready) || (result.valid && result.ready)
        || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    board.write_reg(idx, d);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] z,
                             logic [H_W-1:0] h);
    while ($urandom_range(99) < send_idle) begin
      vertex.valid <= 0;
      @(posedge clk);
    end
    vertex.valid <= 1;
    vertex.vertex_x <= x;
    vertex.vertex_z <= z;
    vertex.current_height <= h;
    @(posedge clk);
    while (!vertex.ready) @(posedge clk);
    board.note_vertex(x, z, h);
  endtask

  // Wait until every expected result has come, then let the pipe settle.
  task automatic drain();
    vertex.valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_slope(int unsigned ax, int unsigned az, int ah,
                           int unsigned bx, int unsigned bz, int bh, int unsigned rad);
    write_reg(REG_START_X, CFG_DATA_W'(ax));
    write_reg(REG_START_Z, CFG_DATA_W'(az));
    write_reg(REG_START_HEIGHT, CFG_DATA_W'(ah));
    write_reg(REG_END_X, CFG_DATA_W'(bx));
    write_reg(REG_END_Z, CFG_DATA_W'(bz));
    write_reg(REG_END_HEIGHT, CFG_DATA_W'(bh));
    write_reg(REG_RADIUS, CFG_DATA_W'(rad));
  endtask

  // A vertex near the current segment, so most land inside the influence radius.
  task automatic send_near(int spread);
    int x, z, t;
    t = int'($urandom_range(120)) - 10;
    x = int'(board.sx) + (int'(board.ex) - int'(board.sx)) * t / 100
        + int'($urandom_range(2 * spread)) - spread;
    z = int'(board.sz) + (int'(board.ez) - int'(board.sz)) * t / 100
        + int'($urandom_range(2 * spread)) - spread;
    if (x < 0) x = 0;
    if (x > 1023) x = 1023;
    if (z < 0) z = 0;
    if (z > 1023) z = 1023;
    send_vertex(COORD_W'(x), COORD_W'(z), H_W'($urandom()));
  endtask

  initial begin
    int phase;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part. With the reset slope both points coincide: the degenerate case.
    send_vertex(0, 0, 24'h123456);
    send_vertex(1023, 1023, 24'h800000);
    drain();
    // Full-range slope with extreme heights and the largest radius.
    set_slope(0, 0, 24'h7FFFFF, 1023, 1023, 24'h800000, 65535);
    send_vertex(0, 0, 24'h800000);           // at the start point
    send_vertex(1023, 1023, 24'h7FFFFF);     // at the end point
    send_vertex(511, 511, 0);                // mid segment
    send_vertex(1023, 0, 24'h7FFFFF);        // far off the segment
    send_vertex(0, 1023, 24'h800000);
    send_vertex(300, 700, 24'h000001);
    drain();
    // Short slope with a small radius: outside, inside, beyond both ends.
    set_slope(100, 100, 24'h001000, 110, 100, 24'hFFF000, 1);
    send_vertex(100, 100, 0);
    send_vertex(105, 100, 24'h000100);
    send_vertex(105, 101, 0);                // outside the radius
    send_vertex(90, 100, 0);                 // before the start
    send_vertex(120, 100, 0);                // past the end
    drain();
    write_reg(REG_RADIUS, 0);                // zero radius: nothing is influenced
    send_vertex(105, 100, 24'h0ABCDE);
    drain();
    write_reg(REG_RADIUS, 768);
    send_vertex(104, 102, 24'h7FFFFF);
    send_vertex(106, 98, 24'h800000);
    drain();

    // Random part in phases with different idling, each with its own slope.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      set_slope($urandom_range(1023), $urandom_range(1023), $urandom(),
                $urandom_range(1023), $urandom_range(1023), $urandom(),
                (phase == 7) ? 65535 : $urandom_range(1, 8000));
      if (phase == 6) begin
        write_reg(REG_END_X, CFG_DATA_W'(board.sx));
        write_reg(REG_END_Z, CFG_DATA_W'(board.sz));      // degenerate slope again
      end
      repeat (60) begin
        if ($urandom_range(3) == 0)
          send_vertex(COORD_W'($urandom_range(1023)), COORD_W'($urandom_range(1023)),
                      H_W'($urandom()));
        else
          send_near($urandom_range(1, 12));
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
design/ssb_pkg.sv
design/ssb_vertex_if.sv
design/ssb_div.sv
design/ssb_sqrt.sv
design/smoothstep_slope_blend.sv
tb/ssb_scoreboard.sv
tb/smoothstep_slope_blend_tb.sv
